// ===== rtl/core/ray_sphere_intersect_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define RSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition never holds outside reset.
`define RSI_NEVER(lbl, cond, msg) \
    `RSI_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/rsi_pkg.sv =====
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int DIR_W     = 18;
    localparam int RAD_W     = 31;
    localparam int THR_W     = 16;
    localparam int OFF_W     = IN_W + 1;
    localparam int DP_W      = OFF_W + DIR_W;
    localparam int DOT_W     = DP_W + 2;
    localparam int SQ_W      = 2 * OFF_W;
    localparam int R2_W      = 2 * RAD_W;
    localparam int CS_W      = SQ_W + 2;
    localparam int BQ_W      = DOT_W + 1 - FRAC_BITS;
    localparam int CQ_W      = CS_W - FRAC_BITS;
    localparam int H_W       = (BQ_W + 1) / 2;
    localparam int PP_W      = 2 * H_W;
    localparam int DISC_A    = 2 * BQ_W;
    localparam int DISC_B    = CS_W + 2;
    localparam int DISC_W    = ((DISC_A > DISC_B) ? DISC_A : DISC_B) + 1;
    localparam int DQ_W      = DISC_W - FRAC_BITS;
    localparam int RT_W      = (DISC_W + 1) / 2;
    localparam int RAD2_W    = 2 * RT_W;
    localparam int REM_W     = RT_W + 2;
    localparam int SUM_W     = RT_W + 2;
    localparam int SAT_W     = DISC_W + 2;
    localparam int OUT_W     = 32;

    typedef struct packed {
        logic signed [IN_W-1:0]  origin_x;
        logic signed [IN_W-1:0]  origin_y;
        logic signed [IN_W-1:0]  origin_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic signed [IN_W-1:0]  center_x;
        logic signed [IN_W-1:0]  center_y;
        logic signed [IN_W-1:0]  center_z;
        logic [RAD_W-1:0]        radius;
    } item_t;

    typedef struct packed {
        logic signed [BQ_W-1:0] bq;
        logic signed [CQ_W-1:0] cq;
        logic [BQ_W-1:0]        mag;
    } geom_t;

    typedef struct packed {
        logic signed [DQ_W-1:0] dq;
        logic signed [BQ_W-1:0] bq;
        logic                   hit;
    } side_t;

    typedef struct packed {
        logic signed [DISC_W-1:0] disc;
        side_t                    side;
    } disc_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] distance;
        logic signed [OUT_W-1:0] penetration;
        logic                    hit;
        logic                    saturated;
    } res_t;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             clip;
    } sat_t;

    typedef enum logic [0:0] {
        REG_SMALL_THRESHOLD = 1'b0
    } reg_idx_t;

    function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
        sat_t r;
        logic [SAT_W-OUT_W:0] hi;
        hi = v[SAT_W-1:OUT_W-1];
        r.clip = !((&hi) || !(|hi));
        if (!r.clip)
            r.val = v[OUT_W-1:0];
        else if (v[SAT_W-1])
            r.val = {1'b1, {(OUT_W-1){1'b0}}};
        else
            r.val = {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ===== rtl/core/rsi_geom.sv =====
module rsi_geom
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  rsi_pkg::item_t item,
    output logic           out_vld,
    output rsi_pkg::geom_t geom
);

    logic signed [rsi_pkg::OFF_W-1:0] off_reg [3];
    logic signed [rsi_pkg::DIR_W-1:0] dir_reg [3];
    logic [rsi_pkg::RAD_W-1:0]        rad_reg;
    logic signed [rsi_pkg::DP_W-1:0]  dp_reg [3];
    logic signed [rsi_pkg::SQ_W-1:0]  sq_reg [3];
    logic [rsi_pkg::R2_W-1:0]         r2_reg;
    logic signed [rsi_pkg::DOT_W-1:0] dot_reg;
    logic signed [rsi_pkg::CS_W-1:0]  cs_reg;
    rsi_pkg::geom_t                   geom_reg;
    logic signed [rsi_pkg::OFF_W-1:0] off_next [3];
    logic signed [rsi_pkg::BQ_W-1:0]  bq_next;
    logic [3:0]                       vld_reg;

    always_comb
    begin
        off_next[0] = $signed({item.origin_x[rsi_pkg::IN_W-1], item.origin_x})
                    - $signed({item.center_x[rsi_pkg::IN_W-1], item.center_x});
        off_next[1] = $signed({item.origin_y[rsi_pkg::IN_W-1], item.origin_y})
                    - $signed({item.center_y[rsi_pkg::IN_W-1], item.center_y});
        off_next[2] = $signed({item.origin_z[rsi_pkg::IN_W-1], item.origin_z})
                    - $signed({item.center_z[rsi_pkg::IN_W-1], item.center_z});
        bq_next = rsi_pkg::BQ_W'(dot_reg >>> (rsi_pkg::FRAC_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i] <= off_next[i];
                dp_reg[i]  <= dir_reg[i] * off_reg[i];
                sq_reg[i]  <= off_reg[i] * off_reg[i];
            end
            dir_reg[0] <= item.dir_x;
            dir_reg[1] <= item.dir_y;
            dir_reg[2] <= item.dir_z;
            rad_reg    <= item.radius;
            r2_reg     <= rad_reg * rad_reg;
            dot_reg    <= rsi_pkg::DOT_W'(dp_reg[0]) + rsi_pkg::DOT_W'(dp_reg[1])
                        + rsi_pkg::DOT_W'(dp_reg[2]);
            cs_reg     <= rsi_pkg::CS_W'(sq_reg[0]) + rsi_pkg::CS_W'(sq_reg[1])
                        + rsi_pkg::CS_W'(sq_reg[2])
                        - $signed({{(rsi_pkg::CS_W - rsi_pkg::R2_W){1'b0}}, r2_reg});
            geom_reg.bq  <= bq_next;
            geom_reg.cq  <= rsi_pkg::CQ_W'(cs_reg >>> rsi_pkg::FRAC_BITS);
            geom_reg.mag <= bq_next[rsi_pkg::BQ_W-1] ? rsi_pkg::BQ_W'(-bq_next)
                                                     : rsi_pkg::BQ_W'(bq_next);
        end
    end

    assign out_vld = vld_reg[3];
    assign geom    = geom_reg;

endmodule

// ===== rtl/core/rsi_disc.sv =====
module rsi_disc
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [rsi_pkg::THR_W-1:0] threshold,
    input  logic                      in_vld,
    input  rsi_pkg::geom_t            geom,
    output logic                      out_vld,
    output rsi_pkg::disc_t            disc
);

    localparam int HI_W = rsi_pkg::BQ_W - rsi_pkg::H_W;

    logic [rsi_pkg::PP_W-1:0]          hh_reg;
    logic [rsi_pkg::PP_W-1:0]          hl_reg;
    logic [rsi_pkg::PP_W-1:0]          ll_reg;
    logic signed [rsi_pkg::BQ_W-1:0]   bq_reg;
    logic signed [rsi_pkg::CQ_W-1:0]   cq_reg;
    rsi_pkg::disc_t                    disc_reg;
    logic [1:0]                        vld_reg;
    logic [HI_W-1:0]                   mag_hi;
    logic [rsi_pkg::H_W-1:0]           mag_lo;
    logic [rsi_pkg::DISC_W-1:0]        sq_sum;
    logic signed [rsi_pkg::DISC_W-1:0] cq_ext;
    logic signed [rsi_pkg::DISC_W-1:0] disc_next;
    logic signed [rsi_pkg::DQ_W-1:0]   dq_next;

    always_comb
    begin
        mag_hi    = geom.mag[rsi_pkg::BQ_W-1:rsi_pkg::H_W];
        mag_lo    = geom.mag[rsi_pkg::H_W-1:0];
        sq_sum    = (rsi_pkg::DISC_W'(hh_reg) << (2 * rsi_pkg::H_W))
                  + (rsi_pkg::DISC_W'(hl_reg) << (rsi_pkg::H_W + 1))
                  + rsi_pkg::DISC_W'(ll_reg);
        cq_ext    = rsi_pkg::DISC_W'(cq_reg);
        disc_next = $signed(sq_sum) - (cq_ext <<< (rsi_pkg::FRAC_BITS + 2));
        dq_next   = rsi_pkg::DQ_W'(disc_next >>> rsi_pkg::FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= rsi_pkg::PP_W'(mag_hi * mag_hi);
            hl_reg <= rsi_pkg::PP_W'(mag_hi * mag_lo);
            ll_reg <= rsi_pkg::PP_W'(mag_lo * mag_lo);
            bq_reg <= geom.bq;
            cq_reg <= geom.cq;
            disc_reg.disc     <= disc_next;
            disc_reg.side.dq  <= dq_next;
            disc_reg.side.bq  <= bq_reg;
            disc_reg.side.hit <= dq_next >= $signed(rsi_pkg::DQ_W'(threshold));
        end
    end

    assign out_vld = vld_reg[1];
    assign disc    = disc_reg;

endmodule

// ===== rtl/core/rsi_sqrt.sv =====
module rsi_sqrt
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  rsi_pkg::disc_t           disc,
    output logic                     out_vld,
    output logic [rsi_pkg::RT_W-1:0] root,
    output rsi_pkg::side_t           side
);

    localparam int N = rsi_pkg::RT_W;

    logic [rsi_pkg::REM_W-1:0]  rem_reg  [N];
    logic [rsi_pkg::RT_W-1:0]   root_reg [N];
    logic [rsi_pkg::RAD2_W-1:0] rad_reg  [N];
    rsi_pkg::side_t             side_reg [N];
    logic [N-1:0]               vld_reg;
    logic [rsi_pkg::REM_W-1:0]  st_rem   [N];
    logic [rsi_pkg::RT_W-1:0]   st_root  [N];
    logic [rsi_pkg::RAD2_W-1:0] st_rad   [N];
    rsi_pkg::side_t             st_side  [N];
    logic [N-1:0]               st_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= st_vld;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [rsi_pkg::REM_W-1:0] rem_sh;
        logic [rsi_pkg::REM_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign st_rem[k]  = '0;
            assign st_root[k] = '0;
            assign st_rad[k]  = disc.side.hit
                              ? rsi_pkg::RAD2_W'($unsigned(disc.disc)) : '0;
            assign st_side[k] = disc.side;
            assign st_vld[k]  = in_vld;
        end
        else
        begin : g_next
            assign st_rem[k]  = rem_reg[k-1];
            assign st_root[k] = root_reg[k-1];
            assign st_rad[k]  = rad_reg[k-1];
            assign st_side[k] = side_reg[k-1];
            assign st_vld[k]  = vld_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {st_rem[k][rsi_pkg::REM_W-3:0],
                      st_rad[k][rsi_pkg::RAD2_W-1 -: 2]};
            trial  = {st_root[k], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {st_root[k][rsi_pkg::RT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {st_root[k][rsi_pkg::RT_W-2:0], 1'b0};
                end
                rad_reg[k]  <= st_rad[k] << 2;
                side_reg[k] <= st_side[k];
            end
        end
    end

    assign out_vld = vld_reg[N-1];
    assign root    = root_reg[N-1];
    assign side    = side_reg[N-1];

endmodule

// ===== rtl/core/rsi_out.sv =====
module rsi_out
(
    input  logic                     clk,
    input  logic                     rst_n,
    output logic                     en,
    input  logic                     in_vld,
    input  logic [rsi_pkg::RT_W-1:0] root,
    input  rsi_pkg::side_t           side,
    output logic                     out_vld,
    input  logic                     out_rdy,
    output rsi_pkg::res_t            res
);

    logic signed [rsi_pkg::SUM_W-1:0] sum;
    logic signed [rsi_pkg::SAT_W-1:0] neg;
    rsi_pkg::sat_t                    dist_sat;
    rsi_pkg::sat_t                    pen_sat;
    rsi_pkg::res_t                    res_next;
    rsi_pkg::res_t                    res_reg;
    rsi_pkg::res_t                    out_reg;
    rsi_pkg::res_t                    skid_reg;
    logic                             res_vld_reg;
    logic                             out_vld_reg;
    logic                             skid_vld_reg;
    logic                             push;
    logic                             take;

    always_comb
    begin
        sum      = rsi_pkg::SUM_W'(side.bq) + $signed({2'b00, root});
        neg      = -rsi_pkg::SAT_W'(sum);
        dist_sat = rsi_pkg::sat32(neg >>> 1);
        if (side.hit)
        begin
            pen_sat = rsi_pkg::sat32($signed(rsi_pkg::SAT_W'(root)));
            res_next.distance  = dist_sat.val;
            res_next.saturated = dist_sat.clip | pen_sat.clip;
        end
        else
        begin
            pen_sat = rsi_pkg::sat32(rsi_pkg::SAT_W'(side.dq));
            res_next.distance  = '0;
            res_next.saturated = pen_sat.clip;
        end
        res_next.penetration = pen_sat.val;
        res_next.hit         = side.hit;
    end

    assign en   = !skid_vld_reg;
    assign push = res_vld_reg && en;
    assign take = !out_vld_reg || out_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
                res_vld_reg <= in_vld;
            if (take)
            begin
                out_vld_reg  <= skid_vld_reg || push;
                skid_vld_reg <= 1'b0;
            end
            else if (push)
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
        if (take)
            out_reg <= skid_vld_reg ? skid_reg : res_reg;
        else if (push)
            skid_reg <= res_reg;
    end

    assign out_vld = out_vld_reg;
    assign res     = out_reg;

endmodule

// ===== rtl/core/ray_sphere_intersect.sv =====
// Ray and sphere intersection in signed Q16.16: one request is taken per clock while
// s_tready is high, and every request yields exactly one result, in order. The square
// root resolves one root bit per pipeline stage (39 stages); the offsets, products and
// discriminant take six stages before it and the saturation and output register two
// after it. A stall on the output fills a one-entry skid register first, so s_tready
// drops only in the cycle after m_tready has held the output. The miss threshold lives
// at byte address 0 of the APB port and should be written only while no request is in
// flight.
module ray_sphere_intersect
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y, center_z,
    // radius, then three unused bits.
    input  logic [279:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance, penetration.
    output logic [63:0]  m_tdata,
    // hit, saturated.
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [rsi_pkg::THR_W-1:0] thr_reg;
    rsi_pkg::reg_idx_t         reg_idx;
    rsi_pkg::item_t            item;
    rsi_pkg::geom_t            geom;
    rsi_pkg::disc_t            disc;
    rsi_pkg::side_t            side;
    rsi_pkg::res_t             res;
    logic [rsi_pkg::RT_W-1:0]  root;
    logic                      en;
    logic                      geom_vld;
    logic                      disc_vld;
    logic                      sqrt_vld;

    assign pready  = 1'b1;
    assign reg_idx = rsi_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= rsi_pkg::THR_W'(7);
        else if (psel && penable && pwrite && pready
                 && reg_idx == rsi_pkg::REG_SMALL_THRESHOLD)
            thr_reg <= pwdata[rsi_pkg::THR_W-1:0];
    end

    always_comb
    begin
        unique case (reg_idx)
            rsi_pkg::REG_SMALL_THRESHOLD: prdata = {16'h0000, thr_reg};
            default:                      prdata = '0;
        endcase
    end

    always_comb
    begin
        item.origin_x = s_tdata[31:0];
        item.origin_y = s_tdata[63:32];
        item.origin_z = s_tdata[95:64];
        item.dir_x    = s_tdata[113:96];
        item.dir_y    = s_tdata[131:114];
        item.dir_z    = s_tdata[149:132];
        item.center_x = s_tdata[181:150];
        item.center_y = s_tdata[213:182];
        item.center_z = s_tdata[245:214];
        item.radius   = s_tdata[276:246];
    end

    assign s_tready = en;

    rsi_geom u_geom
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_tvalid),
        .item    (item),
        .out_vld (geom_vld),
        .geom    (geom)
    );

    rsi_disc u_disc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .threshold (thr_reg),
        .in_vld    (geom_vld),
        .geom      (geom),
        .out_vld   (disc_vld),
        .disc      (disc)
    );

    rsi_sqrt u_sqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (disc_vld),
        .disc    (disc),
        .out_vld (sqrt_vld),
        .root    (root),
        .side    (side)
    );

    rsi_out u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sqrt_vld),
        .root    (root),
        .side    (side),
        .out_vld (m_tvalid),
        .out_rdy (m_tready),
        .res     (res)
    );

    assign m_tdata = {res.penetration, res.distance};
    assign m_tuser = {res.saturated, res.hit};

endmodule

// ===== rtl/core/rsi_checker.sv =====
`include "ray_sphere_intersect_macros.svh"

module rsi_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         pready
);

    logic [65:0] m_word;

    assign m_word = {m_tuser, m_tdata};

    `RSI_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_word), "held result changed")
    `RSI_ASSERT(a_miss_zero, m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'h0, "miss with distance")
    `RSI_ASSERT(a_ready_drop, $fell(s_tready) |-> $past(m_tvalid && !m_tready), "ready fell unstalled")
    `RSI_NEVER(a_pready, !pready, "pready low")

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
